// ===== design/pf_pkg.sv =====
// shared constants and types for the prime factorizer
`default_nettype none

package pf_pkg;

  // width of the value to factor
  localparam int unsigned VALUE_BITS = 31;
  // trial divisors stay just above the square root of the value
  localparam int unsigned DIV_BITS   = VALUE_BITS / 2 + 1;
  // step counter of the serial divider, holds VALUE_BITS itself
  localparam int unsigned CNT_BITS   = $clog2(VALUE_BITS + 1);

  // quotient and remainder of one trial division
  typedef struct packed {
    logic [VALUE_BITS-1:0] quo;
    logic [DIV_BITS-1:0]   rem;
  } div_res_t;

endpackage : pf_pkg

`default_nettype wire

// ===== design/prime_factorizer_top.sv =====
// prime factorizer top level: trial-division sequencer and output register
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------
//  in      | in_valid_i  | in_stall_o  | value_i
//  out     | out_valid_o | out_stall_i | factor_o, last_o, none_o
//
// each trial divisor is worked by the bit-serial divider (one quotient bit
// per cycle); a 31-bit prime takes about 23200 trials, and each emitted
// factor passes through the S_EMIT state.
// one item is factored at a time; in_stall_o is high from acceptance until
// the last factor is in the output register. a stalled output holds the
// sequencer. reset clears the control state, no clearing pass.
`default_nettype none

module prime_factorizer_top
  import pf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [VALUE_BITS-1:0] factor_o,
  output      logic                  last_o,
  output      logic                  none_o
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [1:0]            after_q, after_d;
  logic [VALUE_BITS-1:0] remain_q, remain_d;
  logic [DIV_BITS-1:0]   trial_q, trial_d;
  logic [VALUE_BITS-1:0] pend_factor_q, pend_factor_d;
  logic                  pend_last_q, pend_last_d;
  logic                  pend_none_q, pend_none_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] factor_q;
  logic                  last_q;
  logic                  none_q;

  logic                  in_accept;
  logic                  out_free;
  logic                  emit;
  logic                  div_start;
  logic                  div_done;
  div_res_t              div_res;
  logic [VALUE_BITS-1:0] trial_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == S_EMIT) && out_free;
  assign trial_wide = {{(VALUE_BITS-DIV_BITS){1'b0}}, trial_q};

  pf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (remain_q),
    .divisor_i  (trial_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // trial-division sequencer
  always_comb begin
    state_d       = state_q;
    after_d       = after_q;
    remain_d      = remain_q;
    trial_d       = trial_q;
    pend_factor_d = pend_factor_q;
    pend_last_d   = pend_last_q;
    pend_none_d   = pend_none_q;
    div_start     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          remain_d = value_i;
          trial_d  = DIV_BITS'(2);
          state_d  = S_START;
        end
      end
      S_START: begin
        if (remain_q <= VALUE_BITS'(1)) begin
          // zero or one: single item with the none flag
          pend_factor_d = '0;
          pend_last_d   = 1'b1;
          pend_none_d   = 1'b1;
          after_d       = S_IDLE;
          state_d       = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_res.quo < trial_wide) begin
            // divisor squared exceeds remainder: what is left is prime
            pend_factor_d = remain_q;
            pend_last_d   = 1'b1;
            pend_none_d   = 1'b0;
            after_d       = S_IDLE;
            state_d       = S_EMIT;
          end else if (div_res.rem == '0) begin
            // quotient is at least the divisor, so more factors follow
            pend_factor_d = trial_wide;
            pend_last_d   = 1'b0;
            pend_none_d   = 1'b0;
            remain_d      = div_res.quo;
            after_d       = S_START;
            state_d       = S_EMIT;
          end else begin
            trial_d = (trial_q == DIV_BITS'(2)) ? DIV_BITS'(3)
                                                : trial_q + DIV_BITS'(2);
            state_d = S_START;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = after_q;
        end
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      after_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      after_q     <= after_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    remain_q      <= remain_d;
    trial_q       <= trial_d;
    pend_factor_q <= pend_factor_d;
    pend_last_q   <= pend_last_d;
    pend_none_q   <= pend_none_d;
    if (emit) begin
      factor_q <= pend_factor_q;
      last_q   <= pend_last_q;
      none_q   <= pend_none_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;
  assign none_o      = none_q;

endmodule : prime_factorizer_top

`default_nettype wire

// ===== design/pf_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module pf_div
  import pf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [DIV_BITS-1:0]   divisor_i,
  output      logic                  done_o,
  output      div_res_t              res_o
);

  logic                  run_q, run_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [DIV_BITS-1:0]   dvs_q, dvs_d;
  logic [DIV_BITS:0]     shifted;
  logic [DIV_BITS:0]     diff;

  // one restoring step: bring in the next dividend bit and try a subtract
  assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_BITS'(VALUE_BITS);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CNT_BITS'(1);
        if (!diff[DIV_BITS]) begin
          rem_d = diff[DIV_BITS-1:0];
          quo_d = {quo_q[VALUE_BITS-2:0], 1'b1};
        end else begin
          rem_d = shifted[DIV_BITS-1:0];
          quo_d = {quo_q[VALUE_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o    = run_q && (cnt_q == '0);
  assign res_o.quo = quo_q;
  assign res_o.rem = rem_q;

endmodule : pf_div

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for the prime factorizer: directed and random values against a predictor
`timescale 1ns / 100ps

module tb;
  import pf_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 4;
  // slowest run is dominated by the 31-bit prime
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned HOLD_AFTER   = 12;
  localparam int unsigned SHOW_LIMIT   = 10;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t factor;
    logic   last;
    logic   none;
  } factor_item_t;

  // directed values: zero and one, small primes and squares, powers of two,
  // alternating bit patterns, many small factors and the largest value
  localparam int unsigned NUM_DIRECTED = 18;
  localparam value_t DIRECTED_VALUES [0:NUM_DIRECTED-1] = '{
    31'd1, 31'd0, 31'd2, 31'd3, 31'd4, 31'd9, 31'd121, 31'd6, 31'd30,
    31'd65521, 31'd65537, 31'd1073741824, 31'd1073741823, 31'd1431655765,
    31'd715827882, 31'd2147483646, 31'd223092870, 31'd2147483647
  };

  // expected factor lists and the checks against them
  class factor_board;
    factor_item_t pending_factors[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  longest_list;

    function new();
      mismatches   = 0;
      checked      = 0;
      longest_list = 0;
    endfunction

    function int unsigned outstanding();
      return pending_factors.size();
    endfunction

    // append one expected item at the tail
    function void queue_item(factor_item_t item);
      pending_factors = {pending_factors, item};
    endfunction

    // trial division: 2 first, then odd divisors while d*d <= rest
    function void note_input(value_t v);
      value_t              rest;
      logic [DIV_BITS-1:0] d;
      bit                  running;
      int unsigned         count;
      rest  = v;
      d     = DIV_BITS'(2);
      count = 0;
      if (rest <= 1) begin
        queue_item('{factor: '0, last: 1'b1, none: 1'b1});
        count = 1;
      end else begin
        running = 1'b1;
        while (running) begin
          if (d > rest / d) begin
            if (rest > 1) begin
              queue_item('{factor: rest, last: 1'b0, none: 1'b0});
              count++;
            end
            running = 1'b0;
          end else if (rest % d == 0) begin
            queue_item('{factor: value_t'(d), last: 1'b0, none: 1'b0});
            count++;
            rest = rest / d;
          end else begin
            d = (d == DIV_BITS'(2)) ? DIV_BITS'(3) : d + DIV_BITS'(2);
          end
        end
        // mark the final factor of this value
        pending_factors[pending_factors.size() - 1].last = 1'b1;
      end
      if (count > longest_list) longest_list = count;
    endfunction

    function void check_result(value_t f, logic l, logic n);
      factor_item_t exp_item;
      checked++;
      if (pending_factors.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected factor %0d last=%0b none=%0b with nothing pending",
                   f, l, n);
        return;
      end
      exp_item = pending_factors.pop_front();
      if (f !== exp_item.factor || l !== exp_item.last || n !== exp_item.none) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("factor %0d mismatch: expected %0d last=%0b none=%0b, %s %0d last=%0b none=%0b",
                   checked, exp_item.factor, exp_item.last, exp_item.none, "got",
                   f, l, n);
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  value_t value_i;
  logic   out_valid_o;
  logic   out_stall_i;
  value_t factor_o;
  logic   last_o;
  logic   none_o;

  factor_board sb = new();
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned held_cycles = 0;
  bit          held        = 1'b0;

  prime_factorizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .factor_o    (factor_o),
    .last_o      (last_o),
    .none_o      (none_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // offer one value and hold it until the block takes it
  task automatic send_value(input value_t v);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(v);
    items_sent++;
  endtask

  // gap after an item: bursts without gaps, often short gaps, a few long
  task automatic idle_sender();
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) burst_left = $urandom_range(5, 15);
      else if (r < 45) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      value_i    <= value_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // mostly small values; shifted small parts reach the upper bits cheaply
  function automatic value_t random_value();
    int unsigned r;
    int unsigned m;
    int unsigned s;
    r = $urandom_range(0, 99);
    if (r < 3) return value_t'($urandom_range(0, 1));
    else if (r < 38) return value_t'($urandom_range(2, 1023));
    else if (r < 68) return value_t'($urandom_range(1024, 65535));
    else if (r < 93) begin
      m = $urandom_range(1, 4095);
      s = $urandom_range(0, 30);
      return value_t'(m << s);
    end
    else return value_t'($urandom_range(65536, 1 << 20));
  endfunction

  // stimulus and end of run
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    value_i    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_value(DIRECTED_VALUES[i]);
      idle_sender();
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_value(random_value());
      idle_sender();
    end
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("factored %0d values (%0d directed, incl. 0, 1, 2^30 and the 31-bit maximum)",
             items_sent, NUM_DIRECTED);
    $display("%0d factors checked, longest list %0d, output held off %0d cycles",
             sb.checked, sb.longest_list, held_cycles);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // output side: check accepted factors, random stall with one long hold
  initial begin
    int unsigned stall_run;
    int unsigned calm_run;
    int unsigned r;
    stall_run = 0;
    calm_run  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(factor_o, last_o, none_o);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held      = 1'b1;
        stall_run = HOLD_CYCLES;
        calm_run  = 0;
      end else if (stall_run == 0 && calm_run == 0) begin
        r = $urandom_range(0, 99);
        if (r < 3) stall_run = $urandom_range(20, 60);
        else if (r < 8) calm_run = $urandom_range(50, 200);
        else if (r < 30) stall_run = $urandom_range(1, 3);
      end
      if (stall_run > 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
        if (held && held_cycles < HOLD_CYCLES) held_cycles++;
      end else begin
        out_stall_i <= 1'b0;
        if (calm_run > 0) calm_run--;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d factors still pending",
             cycle_count, sb.outstanding());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
